// ===== sv/tec_pkg.sv =====
// Shared types and constants for the text expression calculator.
package tec_pkg;

  // Character codes recognized by the line parser.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Operator codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PARSE = 2'd1;
  localparam logic [1:0] STAT_DIV0  = 2'd2;

  // Data width and the step counter of the multiply and divide loops.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  // Parser position within the line.
  typedef enum logic [2:0] {
    PH_LEFT_START,
    PH_LEFT_DIGITS,
    PH_OP_WAIT,
    PH_RIGHT_START,
    PH_RIGHT_DIGIT,
    PH_TAIL
  } parse_phase_t;

  // Evaluation sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIGN_A,
    ST_SIGN_B,
    ST_ADD,
    ST_MUL,
    ST_ABS_A,
    ST_ABS_B,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } eval_state_t;

endpackage

// ===== sv/text_expression_calculator_top.sv =====
// Character-stream parser and evaluator for one "a op b" line per result.
//
// Characters are taken one per beat on the char channel when not stalled, and
// the parser state advances as they arrive. A beat with line_end high ends the
// line and starts evaluation on a single shared 33-bit adder/subtractor that a
// small sequencer steps through sign fixing, a 32-step shift-add multiply or a
// 32-step restoring divide. The char channel stalls from the cycle after the
// end-of-line beat until the result has been loaded into the output register.
// A parse error or divide by zero goes straight to the output state, while a
// valid line first runs the sign fixing and its operation on the shared adder.
// If the previous result still waits on the result channel, the load and the
// stall stretch until that beat is taken.
// Characters of the next line are taken while a finished result still waits
// on the result channel.
module text_expression_calculator_top
  import tec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         ch,
  input  logic               line_end,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic signed [31:0] value
);

  // Parser registers.
  parse_phase_t      phase, phase_next;
  logic [DATA_W-1:0] left_acc, left_acc_next;
  logic              left_neg, left_neg_next;
  logic [DATA_W-1:0] num_acc, num_acc_next;
  logic              num_neg, num_neg_next;
  logic              digit_seen, digit_seen_next;
  logic [1:0]        op_code, op_code_next;
  logic              syn_fail, syn_fail_next;

  // Sequencer and evaluation registers.
  eval_state_t       state, state_next;
  logic [DATA_W-1:0] op_a, op_b, work, rem;
  logic              a_neg, b_neg, neg_res;
  logic [1:0]        eval_op, pend_status;
  logic [STEP_W-1:0] step;

  // Shared adder/subtractor.
  logic [DATA_W:0]   alu_x, alu_y, alu_sum;
  logic              alu_sub;

  logic              char_take, line_take, complete;
  logic              is_blank, is_digit, is_op;
  logic [1:0]        ch_op;
  logic [DATA_W-1:0] acc_times10, rem_sh;
  logic              out_load;

  assign char_stall = (state != ST_IDLE);
  assign char_take  = char_valid && (state == ST_IDLE);
  assign line_take  = char_take && line_end;

  // Character classes.
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  always_comb begin
    is_op = 1'b1;
    ch_op = OP_ADD;
    case (ch)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      CH_SLASH: ch_op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  // Decimal accumulate: acc * 10 + digit, wrapping at 32 bits.
  assign acc_times10 = (num_acc << 3) + (num_acc << 1) + {{(DATA_W-4){1'b0}}, ch[3:0]};

  assign complete = !syn_fail &&
                    (((phase == PH_RIGHT_DIGIT) && digit_seen) || (phase == PH_TAIL));

  // Next parser state for one character.
  always_comb begin
    phase_next      = phase;
    left_acc_next   = left_acc;
    left_neg_next   = left_neg;
    num_acc_next    = num_acc;
    num_neg_next    = num_neg;
    digit_seen_next = digit_seen;
    op_code_next    = op_code;
    syn_fail_next   = syn_fail;
    if (!syn_fail) begin
      unique case (phase)
        PH_LEFT_START, PH_RIGHT_START: begin
          if (!is_blank) begin
            if (ch == CH_PLUS || ch == CH_MINUS || is_digit) begin
              phase_next = (phase == PH_LEFT_START) ? PH_LEFT_DIGITS : PH_RIGHT_DIGIT;
              if (ch == CH_MINUS) begin
                num_neg_next = 1'b1;
              end
              if (is_digit) begin
                num_acc_next    = acc_times10;
                digit_seen_next = 1'b1;
              end
            end else begin
              syn_fail_next = 1'b1;
            end
          end
        end
        PH_LEFT_DIGITS, PH_OP_WAIT: begin
          if (phase == PH_LEFT_DIGITS && is_digit) begin
            num_acc_next    = acc_times10;
            digit_seen_next = 1'b1;
          end else if (phase == PH_LEFT_DIGITS && !digit_seen) begin
            syn_fail_next = 1'b1;
          end else begin
            // Leaving the left operand keeps its magnitude and sign.
            if (phase == PH_LEFT_DIGITS) begin
              left_acc_next = num_acc;
              left_neg_next = num_neg;
            end
            if (is_blank) begin
              phase_next = PH_OP_WAIT;
            end else if (is_op) begin
              op_code_next    = ch_op;
              num_acc_next    = '0;
              num_neg_next    = 1'b0;
              digit_seen_next = 1'b0;
              phase_next      = PH_RIGHT_START;
            end else begin
              syn_fail_next = 1'b1;
            end
          end
        end
        PH_RIGHT_DIGIT: begin
          if (is_digit) begin
            num_acc_next    = acc_times10;
            digit_seen_next = 1'b1;
          end else if (!digit_seen || !is_blank) begin
            syn_fail_next = 1'b1;
          end else begin
            phase_next = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (!is_blank) begin
            syn_fail_next = 1'b1;
          end
        end
        default: syn_fail_next = 1'b1;
      endcase
    end
  end

  // Parser registers: advance on characters, return to start on end of line.
  always_ff @(posedge clk) begin
    if (rst || line_take) begin
      phase      <= PH_LEFT_START;
      left_acc   <= '0;
      left_neg   <= 1'b0;
      num_acc    <= '0;
      num_neg    <= 1'b0;
      digit_seen <= 1'b0;
      op_code    <= OP_ADD;
      syn_fail   <= 1'b0;
    end else if (char_take) begin
      phase      <= phase_next;
      left_acc   <= left_acc_next;
      left_neg   <= left_neg_next;
      num_acc    <= num_acc_next;
      num_neg    <= num_neg_next;
      digit_seen <= digit_seen_next;
      op_code    <= op_code_next;
      syn_fail   <= syn_fail_next;
    end
  end

  // Divide step: shift the next dividend bit into the partial remainder.
  assign rem_sh = {rem[DATA_W-2:0], work[DATA_W-1]};

  // Operand selection for the shared adder.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_SIGN_A: begin
        alu_y   = {1'b0, op_a};
        alu_sub = a_neg;
      end
      ST_SIGN_B: begin
        alu_y   = {1'b0, op_b};
        alu_sub = b_neg;
      end
      ST_ADD: begin
        alu_x   = {1'b0, op_a};
        alu_y   = {1'b0, op_b};
        alu_sub = (eval_op == OP_SUB);
      end
      ST_MUL: begin
        alu_x = {1'b0, work};
        alu_y = op_b[0] ? {1'b0, op_a} : '0;
      end
      ST_ABS_A: begin
        alu_y   = {1'b0, op_a};
        alu_sub = op_a[DATA_W-1];
      end
      ST_ABS_B: begin
        alu_y   = {1'b0, op_b};
        alu_sub = op_b[DATA_W-1];
      end
      ST_DIV: begin
        alu_x   = {1'b0, rem_sh};
        alu_y   = {1'b0, op_b};
        alu_sub = 1'b1;
      end
      ST_FIX: begin
        alu_y   = {1'b0, work};
        alu_sub = neg_res;
      end
      ST_IDLE, ST_OUT: begin
        alu_sub = 1'b0;
      end
      default: alu_sub = 1'b0;
    endcase
  end

  assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{DATA_W{1'b0}}, alu_sub};

  assign out_load = (state == ST_OUT) && (!result_valid || !result_stall);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (line_take) begin
          if (!complete || (op_code == OP_DIV && num_acc == '0)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_SIGN_A;
          end
        end
      end
      ST_SIGN_A: state_next = ST_SIGN_B;
      ST_SIGN_B: begin
        unique case (eval_op)
          OP_ADD, OP_SUB: state_next = ST_ADD;
          OP_MUL:         state_next = ST_MUL;
          OP_DIV:         state_next = ST_ABS_A;
          default:        state_next = ST_ADD;
        endcase
      end
      ST_ADD:   state_next = ST_OUT;
      ST_MUL:   state_next = (step == LAST_STEP) ? ST_OUT : ST_MUL;
      ST_ABS_A: state_next = ST_ABS_B;
      ST_ABS_B: state_next = ST_DIV;
      ST_DIV:   state_next = (step == LAST_STEP) ? ST_FIX : ST_DIV;
      ST_FIX:   state_next = ST_OUT;
      ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Evaluation datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (line_take) begin
          op_a    <= left_acc;
          a_neg   <= left_neg;
          op_b    <= num_acc;
          b_neg   <= num_neg;
          eval_op <= op_code;
          step    <= '0;
          work    <= '0;
          rem     <= '0;
          neg_res <= 1'b0;
          if (!complete) begin
            pend_status <= STAT_PARSE;
          end else if (op_code == OP_DIV && num_acc == '0) begin
            pend_status <= STAT_DIV0;
          end else begin
            pend_status <= STAT_OK;
          end
        end
      end
      ST_SIGN_A: op_a <= alu_sum[DATA_W-1:0];
      ST_SIGN_B: op_b <= alu_sum[DATA_W-1:0];
      ST_ADD:    work <= alu_sum[DATA_W-1:0];
      ST_MUL: begin
        work <= alu_sum[DATA_W-1:0];
        op_a <= op_a << 1;
        op_b <= op_b >> 1;
        step <= step + 1'b1;
      end
      ST_ABS_A: begin
        neg_res <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
        work    <= alu_sum[DATA_W-1:0];
      end
      ST_ABS_B: op_b <= alu_sum[DATA_W-1:0];
      ST_DIV: begin
        // A borrow out of the top bit means the divisor did not fit.
        work <= {work[DATA_W-2:0], ~alu_sum[DATA_W]};
        rem  <= alu_sum[DATA_W] ? rem_sh : alu_sum[DATA_W-1:0];
        step <= step + 1'b1;
      end
      ST_FIX: work <= alu_sum[DATA_W-1:0];
      ST_OUT: begin
        work <= work;
      end
      default: work <= work;
    endcase
  end

  // Output register: holds a result until the consumer takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= pend_status;
      value  <= (pend_status == STAT_OK) ? signed'(work) : '0;
    end
  end

endmodule

// ===== sv/tec_checker.sv =====
// Port-level checks for the text expression calculator, bound to its top level.
module tec_checker
  import tec_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               char_valid,
  input logic               char_stall,
  input logic               line_end,
  input logic               result_valid,
  input logic               result_stall,
  input logic [1:0]         status,
  input logic signed [31:0] value
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(value))
    else $error("stalled result beat changed");

  // Status is always one of the three defined codes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == STAT_OK) || (status == STAT_PARSE) || (status == STAT_DIV0))
    else $error("undefined status code");

  // Error results carry a zero value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STAT_OK) |-> value == '0)
    else $error("nonzero value with error status");

  // An end-of-line beat starts evaluation, which holds off the next character.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && line_end |=> char_stall)
    else $error("char channel open right after end of line");

endmodule

bind text_expression_calculator_top tec_checker u_tec_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_stall   (char_stall),
  .line_end     (line_end),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .value        (value)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the text expression calculator top level.
module tb_top
  import tec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BEAT_TARGET = 1400;
  localparam int HOLD_CYCLES = 300;

  // One expected or observed line result.
  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
  } calc_result_t;

  logic               clk;
  logic               rst;
  logic               char_valid;
  logic               char_stall;
  logic [7:0]         ch;
  logic               line_end;
  logic               result_valid;
  logic               result_stall;
  logic [1:0]         status;
  logic signed [31:0] value;

  text_expression_calculator_top uut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .ch           (ch),
    .line_end     (line_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .value        (value)
  );

  // Parser state mirrored by the predictor.
  parse_phase_t phase;
  logic [31:0]  left_value;
  logic [31:0]  number_acc;
  bit           number_neg;
  bit           digit_seen;
  logic [1:0]   op_code;
  bit           syntax_bad;

  calc_result_t line_results[$];
  logic [7:0]   line_buf[$];
  logic [7:0]   op_chars[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  int  fail_count = 0;
  int  beats_sent = 0;
  int  lines_sent = 0;
  int  ok_seen = 0;
  int  parse_seen = 0;
  int  div0_seen = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout at %0t with %0d results outstanding.", $time, line_results.size());
    $display("text_expression_calculator_top verification failed");
    $finish;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] signed_number();
    return number_neg ? (32'd0 - number_acc) : number_acc;
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  function automatic void clear_number();
    number_acc = '0;
    number_neg = 1'b0;
    digit_seen = 1'b0;
  endfunction

  function automatic void clear_parser();
    phase      = PH_LEFT_START;
    left_value = '0;
    op_code    = OP_ADD;
    syntax_bad = 1'b0;
    clear_number();
  endfunction

  function automatic void add_digit(logic [7:0] c);
    number_acc = number_acc * 32'd10 + {24'd0, c - CH_ZERO};
    digit_seen = 1'b1;
  endfunction

  // Leading blanks, an optional sign or the first digit of an operand.
  function automatic void start_operand(logic [7:0] c, parse_phase_t digit_phase);
    if (is_blank(c)) return;
    if (c == CH_PLUS) begin
      phase = digit_phase;
    end else if (c == CH_MINUS) begin
      number_neg = 1'b1;
      phase = digit_phase;
    end else if (is_digit(c)) begin
      add_digit(c);
      phase = digit_phase;
    end else begin
      syntax_bad = 1'b1;
    end
  endfunction

  // Blanks or the operator after the left operand.
  function automatic void wait_operator(logic [7:0] c);
    if (is_blank(c)) begin
      phase = PH_OP_WAIT;
      return;
    end
    case (c)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      CH_SLASH: op_code = OP_DIV;
      default: begin
        syntax_bad = 1'b1;
        return;
      end
    endcase
    clear_number();
    phase = PH_RIGHT_START;
  endfunction

  // Advance the mirrored parser by one character.
  function automatic void advance_parser(logic [7:0] c);
    if (syntax_bad) return;
    case (phase)
      PH_LEFT_START: start_operand(c, PH_LEFT_DIGITS);
      PH_LEFT_DIGITS: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else if (!digit_seen) begin
          syntax_bad = 1'b1;
        end else begin
          left_value = signed_number();
          wait_operator(c);
        end
      end
      PH_OP_WAIT: wait_operator(c);
      PH_RIGHT_START: start_operand(c, PH_RIGHT_DIGIT);
      PH_RIGHT_DIGIT: begin
        if (is_digit(c)) add_digit(c);
        else if (!digit_seen || !is_blank(c)) syntax_bad = 1'b1;
        else phase = PH_TAIL;
      end
      PH_TAIL: if (!is_blank(c)) syntax_bad = 1'b1;
      default: syntax_bad = 1'b1;
    endcase
  endfunction

  // Evaluate the finished line and return the parser to its start.
  function automatic calc_result_t evaluate_line();
    calc_result_t r;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  q;
    a = left_value;
    b = signed_number();
    r.status = STAT_PARSE;
    r.value  = '0;
    if (!syntax_bad && ((phase == PH_RIGHT_DIGIT && digit_seen) || phase == PH_TAIL)) begin
      r.status = STAT_OK;
      case (op_code)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_MUL: r.value = a * b;
        default: begin
          if (b == 32'd0) begin
            r.status = STAT_DIV0;
          end else begin
            q = magnitude(a) / magnitude(b);
            r.value = (a[31] ^ b[31]) ? (32'd0 - q) : q;
          end
        end
      endcase
    end
    clear_parser();
    return r;
  endfunction

  // Offer one beat on the character channel and update the predictor once taken.
  task automatic send_beat(input logic [7:0] c, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      char_valid <= 1'b0;
      ch         <= 8'($urandom);
      line_end   <= 1'($urandom);
      @(negedge clk);
    end
    char_valid <= 1'b1;
    ch         <= c;
    line_end   <= last;
    do @(posedge clk); while (char_stall);
    beats_sent++;
    if (last) begin
      line_results.push_back(evaluate_line());
      lines_sent++;
    end else begin
      advance_parser(c);
    end
  endtask

  // Send the buffered characters followed by the end-of-line beat.
  task automatic send_buffer();
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_buf.delete();
    push_text(s);
    send_buffer();
  endtask

  // A line with one unprintable or unknown character inside it.
  task automatic send_with_odd(string head, logic [7:0] odd, string tail);
    line_buf.delete();
    push_text(head);
    line_buf.push_back(odd);
    push_text(tail);
    send_buffer();
  endtask

  function automatic void push_blanks();
    int n;
    n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  // Optional sign and digits, weighted toward zero and the 32-bit extremes.
  function automatic void push_number();
    int k;
    int n;
    k = $urandom_range(2);
    if (k == 1) line_buf.push_back(CH_PLUS);
    if (k == 2) line_buf.push_back(CH_MINUS);
    k = $urandom_range(99);
    if (k < 10) begin
      push_text("0");
    end else if (k < 20) begin
      push_text("2147483648");
    end else if (k < 25) begin
      push_text("2147483647");
    end else begin
      n = (k < 35) ? $urandom_range(10, 12) : $urandom_range(1, 4);
      repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  // Mostly well-formed lines with random content, the rest broken or noise.
  function automatic void build_line();
    int r;
    line_buf.delete();
    push_blanks();
    push_number();
    push_blanks();
    line_buf.push_back(op_chars[$urandom_range(3)]);
    push_blanks();
    push_number();
    push_blanks();
    r = $urandom_range(99);
    if (r < 6) begin
      line_buf.delete();
      repeat ($urandom_range(8)) line_buf.push_back(8'($urandom));
    end else if (r < 14) begin
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom);
    end else if (r < 20) begin
      r = $urandom_range(line_buf.size());
      while (line_buf.size() > r) void'(line_buf.pop_back());
    end else if (r < 25) begin
      line_buf.insert($urandom_range(line_buf.size()), 8'($urandom));
    end
  endfunction

  // Receiver side: random stalls, or a counted hold-off when one is requested.
  initial begin
    result_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin
    calc_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (line_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d value %0d",
                 $time, status, value);
        fail_count++;
      end else begin
        want = line_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
          fail_count++;
        end
        if (value !== want.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, value);
          fail_count++;
        end
        case (want.status)
          STAT_OK:   ok_seen++;
          STAT_DIV0: div0_seen++;
          default:   parse_seen++;
        endcase
      end
    end
  end

  // Hand-picked lines for each operator, the extremes and the error cases.
  task automatic test_directed_cases();
    send_text("7+5");
    send_text("\t -12 * +3");
    send_text("100-250");
    send_text("8--3");
    send_text("-7/2");
    send_text("7/-2");
    send_text("9/0");
    send_text("-2147483648/-1");
    send_text("2147483647+1");
    send_text("99999999999*99999999999");
    send_text("4 +\t5  ");
    send_text("5+3\t");
    send_text("");
    send_text("5+");
    send_text("-+3*2");
    send_text("6*-");
    send_text("5+3 4");
    send_text("12 34+1");
    send_text("1x+2");
    send_with_odd("7+", 8'h00, "1");
    send_with_odd("3", 8'hFF, "*2");
    send_with_odd("", 8'h7F, "0-0");
  endtask

  // Back-to-back beats on both channels with no idling at all.
  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (15) begin
      build_line();
      send_buffer();
    end
    calm = 1'b0;
  endtask

  // Receiver holds off while short lines keep coming, so the input backs up.
  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (10) send_text("9*-9");
    send_text("-2147483648/7");
  endtask

  // Random lines until the beat budget is spent.
  task automatic test_random_lines();
    while (beats_sent < BEAT_TARGET) begin
      build_line();
      send_buffer();
    end
  endtask

  // Reset, the test sequence, drain and verdict.
  initial begin
    rst        = 1'b1;
    char_valid = 1'b0;
    ch         = 8'h00;
    line_end   = 1'b0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_steady_stream();
    test_output_backpressure();
    test_random_lines();

    @(negedge clk);
    char_valid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d beats in %0d lines, including stall-free and held-output stretches.",
             beats_sent, lines_sent);
    $display("Results seen: %0d ok, %0d parse errors, %0d divide by zero.",
             ok_seen, parse_seen, div0_seen);
    if (fail_count == 0) begin
      $display("text_expression_calculator_top verification clean");
    end else begin
      $display("text_expression_calculator_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tec_pkg.sv
sv/text_expression_calculator_top.sv
sv/tec_checker.sv
sim/tb_top.sv
